/* hdl/skvt_pkg.sv */
//------------------------------------------------------------------------------
// skvt_pkg
// Shared types and constants of the sorted key/value table.
//------------------------------------------------------------------------------
package skvt_pkg;

    localparam int DEF_CAPACITY    = 64;
    localparam int DEF_KEY_WIDTH   = 64;
    localparam int DEF_VALUE_WIDTH = 64;
    localparam int MAX_W           = 6;
    localparam logic [MAX_W-1:0] MAX_RESET = 6'd63;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_LBOUND = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_DUP       = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT_UP,
        S_SHIFT_DOWN,
        S_DONE
    } state_t;

endpackage

/* hdl/sorted_key_value_table.sv */
//------------------------------------------------------------------------------
// sorted_key_value_table
// Sorted key/value array kept in one synchronous memory of pairs.
//------------------------------------------------------------------------------
// A lookup or lower bound is a linear search from the lowest entry, reading
// one memory entry at a time; an insert or a remove then shifts the entries
// above the position up or down through the memory. One transaction is in
// flight at a time.
// Reset clears the entry count and sets max_reg to 63; memory contents need none.
//------------------------------------------------------------------------------
module sorted_key_value_table
    import skvt_pkg::*;
#(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [MAX_W-1:0]       cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             opcode,
    input  logic [KEY_WIDTH-1:0]   key,
    input  logic [VALUE_WIDTH-1:0] value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             status,
    output logic [VALUE_WIDTH-1:0] found_value,
    output logic [6:0]             position,
    output logic [6:0]             count_after
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = KEY_WIDTH + VALUE_WIDTH;

    logic [EW-1:0] mem [CAPACITY];

    state_t state_reg, state_next;
    logic [MAX_W-1:0] max_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic          rd_phase_reg, rd_phase_next;
    op_t           op_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [EW-1:0] rdata_reg;
    logic [1:0]    st_reg, st_next;
    logic [VALUE_WIDTH-1:0] fv_reg, fv_next;

    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [EW-1:0] wr_data;
    logic          accept;
    logic [KEY_WIDTH-1:0] rkey;
    logic          full;

    assign accept = in_valid && in_ready;
    assign rkey   = rdata_reg[EW-1 -: KEY_WIDTH];
    assign full   = (count_reg > CW'(max_reg)) || (count_reg >= CW'(CAPACITY));

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            max_reg      <= MAX_RESET;
            count_reg    <= '0;
            idx_reg      <= '0;
            pos_reg      <= '0;
            rd_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            pos_reg      <= pos_next;
            rd_phase_reg <= rd_phase_next;
            if (cfg_we)
                max_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op_t'(opcode);
            key_reg <= key;
            val_reg <= value;
        end
        st_reg <= st_next;
        fv_reg <= fv_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (accept)
                    state_next = S_SEARCH;
            S_SEARCH:
                if (rd_phase_reg)
                begin
                    if (rkey >= key_reg)
                    begin
                        if (op_reg == OP_INSERT && !full && rkey != key_reg)
                            state_next = S_SHIFT_UP;
                        else if (op_reg == OP_REMOVE && rkey == key_reg)
                            state_next = S_SHIFT_DOWN;
                        else
                            state_next = S_DONE;
                    end
                end
                else if (idx_reg >= count_reg)
                begin
                    if (op_reg == OP_INSERT && !full)
                        state_next = S_SHIFT_UP;
                    else
                        state_next = S_DONE;
                end
            S_SHIFT_UP:
                if (rd_phase_reg && idx_reg == pos_reg)
                    state_next = S_DONE;
                else if (!rd_phase_reg && idx_reg == pos_reg)
                    state_next = S_DONE;
            S_SHIFT_DOWN:
                if (!rd_phase_reg && idx_reg + CW'(1) >= count_reg)
                    state_next = S_DONE;
            S_DONE:
                if (out_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        in_ready      = (state_reg == S_IDLE);
        out_valid     = (state_reg == S_DONE);
        count_next    = count_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        rd_phase_next = 1'b0;
        st_next       = st_reg;
        fv_next       = fv_reg;
        rd_en         = 1'b0;
        rd_addr       = idx_reg[AW-1:0];
        wr_en         = 1'b0;
        wr_addr       = idx_reg[AW-1:0];
        wr_data       = rdata_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                st_next  = ST_OK;
                fv_next  = '0;
            end
            S_SEARCH:
                if (rd_phase_reg)
                begin
                    // Entry idx_reg is in the read register.
                    if (rkey >= key_reg)
                    begin
                        pos_next = idx_reg;
                        if (op_reg == OP_INSERT)
                        begin
                            if (full)
                            begin
                                st_next  = ST_FULL;
                                pos_next = '0;
                            end
                            else if (rkey == key_reg)
                                st_next = ST_DUP;
                            else
                                idx_next = count_reg;
                        end
                        else if (op_reg == OP_LOOKUP)
                        begin
                            if (rkey == key_reg)
                                fv_next = rdata_reg[VALUE_WIDTH-1:0];
                            else
                                st_next = ST_NOT_FOUND;
                        end
                        else if (op_reg == OP_REMOVE)
                        begin
                            if (rkey != key_reg)
                                st_next = ST_NOT_FOUND;
                        end
                    end
                    else
                        idx_next = idx_reg + CW'(1);
                end
                else if (idx_reg >= count_reg)
                begin
                    pos_next = idx_reg;
                    if (op_reg == OP_INSERT)
                    begin
                        if (full)
                        begin
                            st_next  = ST_FULL;
                            pos_next = '0;
                        end
                        else
                            idx_next = count_reg;
                    end
                    else if (op_reg != OP_LBOUND)
                        st_next = ST_NOT_FOUND;
                end
                else
                begin
                    rd_en         = 1'b1;
                    rd_phase_next = 1'b1;
                end
            S_SHIFT_UP:
                // idx_reg walks down from count to pos, moving idx-1 to idx.
                if (idx_reg == pos_reg)
                begin
                    wr_en      = 1'b1;
                    wr_data    = {key_reg, val_reg};
                    count_next = count_reg + CW'(1);
                end
                else if (!rd_phase_reg)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = AW'(idx_reg - CW'(1));
                    rd_phase_next = 1'b1;
                end
                else
                begin
                    wr_en    = 1'b1;
                    idx_next = idx_reg - CW'(1);
                end
            S_SHIFT_DOWN:
                // idx_reg walks up from pos, moving idx+1 to idx.
                if (!rd_phase_reg)
                begin
                    if (idx_reg + CW'(1) >= count_reg)
                        count_next = count_reg - CW'(1);
                    else
                    begin
                        rd_en         = 1'b1;
                        rd_addr       = AW'(idx_reg + CW'(1));
                        rd_phase_next = 1'b1;
                    end
                end
                else
                begin
                    wr_en    = 1'b1;
                    idx_next = idx_reg + CW'(1);
                end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign status      = st_reg;
    assign found_value = fv_reg;
    assign position    = 7'(pos_reg);
    assign count_after = 7'(count_reg);

endmodule

/* tb/sv/tb_sorted_key_value_table.sv */
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_sorted_key_value_table
// Drives insert, lookup, remove and lower-bound transactions into the sorted
// table, predicts each response from a local copy of the sorted array, and
// compares every response field by field. Both handshake sides idle at random.
//------------------------------------------------------------------------------
module tb_sorted_key_value_table;
    import skvt_pkg::*;

    localparam int CAP         = 64;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] found_value;
        logic [6:0]  position;
        logic [6:0]  count_after;
    } resp_t;

    typedef struct {
        op_t         op;
        logic [63:0] k;
        logic [63:0] v;
        bit          has_fixed;
        resp_t       fixed;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [5:0]  cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  opcode = '0;
    logic [63:0] key = '0;
    logic [63:0] value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [63:0] found_value;
    logic [6:0]  position;
    logic [6:0]  count_after;

    // Local image of the table.
    logic [63:0] tbl_keys [CAP];
    logic [63:0] tbl_vals [CAP];
    int          tbl_count;
    logic [5:0]  tbl_limit;

    resp_t       pending_resps [$];
    row_t        directed_rows [$];
    int          fail_count;
    int          cycle_count;
    bit          hold_off;
    logic [63:0] used_keys [$];

    always #5 clk = ~clk;

    sorted_key_value_table u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .key         (key),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .found_value (found_value),
        .position    (position),
        .count_after (count_after)
    );

    function automatic resp_t apply_request(op_t op, logic [63:0] k, logic [63:0] v);
        resp_t r;
        int    pos;
        bit    hit;
        pos = 0;
        while (pos < tbl_count && tbl_keys[pos] < k)
            pos++;
        hit = (pos < tbl_count) && (tbl_keys[pos] == k);
        r.status = ST_OK;
        r.found_value = '0;
        case (op)
            OP_INSERT:
            begin
                if (tbl_count > tbl_limit || tbl_count >= CAP)
                begin
                    r.status = ST_FULL;
                    pos = 0;
                end
                else if (hit)
                    r.status = ST_DUP;
                else
                begin
                    for (int i = tbl_count; i > pos; i--)
                    begin
                        tbl_keys[i] = tbl_keys[i-1];
                        tbl_vals[i] = tbl_vals[i-1];
                    end
                    tbl_keys[pos] = k;
                    tbl_vals[pos] = v;
                    tbl_count++;
                end
            end
            OP_LOOKUP:
            begin
                if (hit)
                    r.found_value = tbl_vals[pos];
                else
                    r.status = ST_NOT_FOUND;
            end
            OP_REMOVE:
            begin
                if (hit)
                begin
                    for (int i = pos; i + 1 < tbl_count; i++)
                    begin
                        tbl_keys[i] = tbl_keys[i+1];
                        tbl_vals[i] = tbl_vals[i+1];
                    end
                    tbl_count--;
                end
                else
                    r.status = ST_NOT_FOUND;
            end
            default:
            begin
            end
        endcase
        r.position = pos[6:0];
        r.count_after = tbl_count[6:0];
        return r;
    endfunction

    task automatic idle_cycles(int n);
        repeat (n) @(posedge clk);
    endtask

    task automatic send_request(op_t op, logic [63:0] k, logic [63:0] v,
                                bit has_fixed, resp_t fixed);
        resp_t predicted;
        predicted = apply_request(op, k, v);
        if (has_fixed && predicted !== fixed)
        begin
            $error("directed row disagrees with table image: op %s key %h", op.name(), k);
            fail_count++;
        end
        pending_resps.push_back(predicted);
        opcode <= op;
        key <= k;
        value <= v;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        in_valid <= 1'b0;
        // The block takes one transaction at a time, so this gap costs nothing.
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending_resps.size() != 0)
            @(posedge clk);
        idle_cycles(2 * CAP + 8);
    endtask

    task automatic write_limit(logic [5:0] lim);
        cfg_we <= 1'b1;
        cfg_wdata <= lim;
        @(posedge clk);
        cfg_we <= 1'b0;
        tbl_limit = lim;
    endtask

    function automatic logic [63:0] pick_key();
        if (used_keys.size() != 0 && $urandom_range(0, 2) != 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        return {$urandom(), $urandom()} & (($urandom_range(0, 3) == 0) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                                        : 64'hFF);
    endfunction

    task automatic random_phase(int n, int ins_weight);
        op_t         op;
        logic [63:0] k;
        resp_t       none;
        none = '0;
        repeat (n)
        begin
            idle_cycles($urandom_range(0, 6));
            op = ($urandom_range(0, 99) < ins_weight) ? OP_INSERT
                                                        : op_t'($urandom_range(1, 3));
            k = pick_key();
            if (op == OP_INSERT)
                used_keys.push_back(k);
            if (used_keys.size() > 100)
                void'(used_keys.pop_front());
            send_request(op, k, {$urandom(), $urandom()}, 1'b0, none);
        end
    endtask

    function automatic resp_t mk(status_t s, logic [63:0] fv, int p, int c);
        resp_t r;
        r.status = s;
        r.found_value = fv;
        r.position = p[6:0];
        r.count_after = c[6:0];
        return r;
    endfunction

    function automatic row_t mk_row(op_t op, logic [63:0] k, logic [63:0] v,
                                    bit has_fixed, resp_t fixed);
        row_t r;
        r.op = op;
        r.k = k;
        r.v = v;
        r.has_fixed = has_fixed;
        r.fixed = fixed;
        return r;
    endfunction

    // Response checker.
    always @(posedge clk)
    begin
        resp_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_resps.size() == 0)
                begin
                    $error("response with nothing outstanding");
                    fail_count++;
                end
                else
                begin
                    want = pending_resps.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        fail_count++;
                    end
                    if (found_value !== want.found_value)
                    begin
                        $error("found_value: expected %h, actual %h",
                               want.found_value, found_value);
                        fail_count++;
                    end
                    if (position !== want.position)
                    begin
                        $error("position: expected %0d, actual %0d", want.position, position);
                        fail_count++;
                    end
                    if (count_after !== want.count_after)
                    begin
                        $error("count_after: expected %0d, actual %0d",
                               want.count_after, count_after);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Receiver: idles a random number of cycles per transaction, and holds off
    // entirely while hold_off is set.
    initial
    begin
        int wait_n;
        @(posedge rst_n);
        forever
        begin
            wait_n = $urandom_range(0, 6);
            if (wait_n != 0 || hold_off)
            begin
                out_ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
                while (hold_off)
                    @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        resp_t none;
        row_t  row;
        none = '0;
        fail_count = 0;
        cycle_count = 0;
        hold_off = 1'b0;
        tbl_count = 0;
        tbl_limit = MAX_RESET;
        idle_cycles(2);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table, key extremes, duplicates, misses, lower bound past the end.
        directed_rows.push_back(mk_row(OP_LOOKUP, 64'd5, '0, 1, mk(ST_NOT_FOUND, 0, 0, 0)));
        directed_rows.push_back(mk_row(OP_REMOVE, 64'd5, '0, 1, mk(ST_NOT_FOUND, 0, 0, 0)));
        directed_rows.push_back(mk_row(OP_LBOUND, '1, '0, 1, mk(ST_OK, 0, 0, 0)));
        directed_rows.push_back(mk_row(OP_INSERT, '1, '1, 1, mk(ST_OK, 0, 0, 1)));
        directed_rows.push_back(mk_row(OP_INSERT, '0, '0, 1, mk(ST_OK, 0, 0, 2)));
        directed_rows.push_back(mk_row(OP_INSERT, 64'h8000_0000_0000_0000,
                                       64'h5555_AAAA_5555_AAAA, 0, none));
        directed_rows.push_back(mk_row(OP_INSERT, '1, 64'd7, 1, mk(ST_DUP, 0, 2, 3)));
        directed_rows.push_back(mk_row(OP_LOOKUP, '1, '0, 1, mk(ST_OK, '1, 2, 3)));
        directed_rows.push_back(mk_row(OP_LOOKUP, 64'h8000_0000_0000_0000, '0, 0, none));
        directed_rows.push_back(mk_row(OP_LOOKUP, 64'd9, '0, 1, mk(ST_NOT_FOUND, 0, 1, 3)));
        directed_rows.push_back(mk_row(OP_LBOUND, 64'h7FFF_FFFF_FFFF_FFFF, '0, 0, none));
        directed_rows.push_back(mk_row(OP_REMOVE, '0, '0, 1, mk(ST_OK, 0, 0, 2)));
        directed_rows.push_back(mk_row(OP_REMOVE, '1, '0, 1, mk(ST_OK, 0, 1, 1)));
        directed_rows.push_back(mk_row(OP_LBOUND, '1, '0, 1, mk(ST_OK, 0, 1, 1)));
        directed_rows.push_back(mk_row(OP_REMOVE, 64'h8000_0000_0000_0000, '0, 0, none));
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_request(row.op, row.k, row.v, row.has_fixed, row.fixed);
            idle_cycles($urandom_range(0, 6));
        end
        drain();

        // Limit of zero: only an insert into an empty table goes in.
        write_limit(6'd0);
        send_request(OP_INSERT, 64'd10, 64'd1, 1, mk(ST_OK, 0, 0, 1));
        send_request(OP_INSERT, 64'd20, 64'd2, 1, mk(ST_FULL, 0, 0, 1));
        drain();

        // Limit of one: one overflow entry allowed beyond the limit.
        write_limit(6'd1);
        send_request(OP_INSERT, 64'd5, 64'd3, 1, mk(ST_OK, 0, 0, 2));
        send_request(OP_INSERT, 64'd30, 64'd4, 1, mk(ST_FULL, 0, 0, 2));
        random_phase(150, 45);
        drain();

        // Maximum limit: an insert-heavy phase that starts while the receiver holds off.
        write_limit(6'd63);
        fork
            begin
                hold_off = 1'b1;
                idle_cycles(400);
                hold_off = 1'b0;
            end
            random_phase(120, 90);
        join
        drain();
        random_phase(400, 50);
        drain();

        write_limit(6'd9);
        random_phase(300, 55);
        drain();

        write_limit(6'd40);
        random_phase(300, 50);
        drain();

        if (fail_count == 0 && pending_resps.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
